@@ rtl/core/ffa_pkg.sv @@
package ffa_pkg;

    localparam int WORD_BYTES = 8;
    localparam int WORD_LOG   = $clog2(WORD_BYTES);
    localparam int POOL_WORDS = 512;
    localparam int PW         = $clog2(POOL_WORDS);
    localparam int SW         = PW + 1;
    localparam int CAP_BYTES  = POOL_WORDS * WORD_BYTES;
    localparam int HDR_BYTES  = 8;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_TOTAL   = 2'd2,
        CMD_LARGEST = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [12:0] request_bytes;
        logic [11:0] data_offset;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [11:0] result_offset;
        logic [12:0] amount;
    } t_res;

    typedef struct packed {
        logic          en;
        logic [PW-1:0] addr;
        logic [SW-1:0] data;
    } t_wr;

endpackage

@@ rtl/core/ffa_mem.sv @@
module ffa_mem (
    input  logic                     i_clk,
    input  ffa_pkg::t_wr             i_wr,
    input  logic                     i_rd_en,
    input  logic [ffa_pkg::PW-1:0]   i_rd_addr,
    output logic [ffa_pkg::SW-1:0]   o_rd_data
);
    import ffa_pkg::*;

    logic [SW-1:0] mem [POOL_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/core/ffa_walk.sv @@
module ffa_walk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ffa_pkg::t_req        i_req,
    input  logic                 i_fmt,
    input  logic [12:0]          i_pool_bytes,
    input  logic                 i_take,
    output logic                 o_idle,
    output logic                 o_done,
    output ffa_pkg::t_res        o_res
);
    import ffa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FMT   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_SPLIT = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [SW-1:0] r_dw, n_dw;
    logic [PW-1:0] r_fw, n_fw;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_end, n_end;
    logic [SW-1:0] r_cur, n_cur;
    logic          r_blk, n_blk;
    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_spl_addr, n_spl_addr;
    logic [SW-1:0] r_spl_val, n_spl_val;
    t_res          r_res, n_res;

    t_wr           wr;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [SW-1:0] rd_data;

    logic          cur_free;
    logic [SW-1:0] cur_mag;
    logic [PW+1:0] nx_sum;
    logic          nx_last;
    logic [PW-1:0] nx;
    logic          merge_go;
    logic          fit;
    logic [PW-1:0] rest;
    logic [PW-1:0] acc_n;
    logic [12:0]   pool_clamp;
    logic [12:0]   pool_adj;
    logic [PW-1:0] el;
    logic [13:0]   req_round;

    ffa_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cur_free = !r_cur[SW-1];
    assign cur_mag  = cur_free ? r_cur : SW'(0 - r_cur);
    assign nx_sum   = (PW+2)'(r_pos) + (PW+2)'(cur_mag) + (PW+2)'(1);
    assign nx_last  = nx_sum >= (PW+2)'(r_end);
    assign nx       = nx_last ? r_end : nx_sum[PW-1:0];
    assign merge_go = cur_free && !nx_last && !r_blk;
    assign fit      = cur_free && (r_cur >= r_dw);
    assign rest     = PW'(r_cur - r_dw);
    assign acc_n    = !cur_free ? r_acc :
                      (r_cmd == CMD_TOTAL) ? PW'(r_acc + r_cur[PW-1:0]) :
                      (r_cur[PW-1:0] > r_acc) ? r_cur[PW-1:0] : r_acc;

    assign pool_clamp = (i_pool_bytes > 13'(CAP_BYTES)) ? 13'(CAP_BYTES) : i_pool_bytes;
    assign pool_adj   = pool_clamp - 13'(HDR_BYTES);
    assign el         = pool_adj[WORD_LOG +: PW];
    assign req_round  = 14'(i_req.request_bytes) + 14'(WORD_BYTES - 1);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_dw       = r_dw;
        n_fw       = r_fw;
        n_pos      = r_pos;
        n_end      = r_end;
        n_cur      = r_cur;
        n_blk      = r_blk;
        n_acc      = r_acc;
        n_spl_addr = r_spl_addr;
        n_spl_val  = r_spl_val;
        n_res      = r_res;
        wr         = '0;
        rd_en      = 1'b0;
        rd_addr    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_fmt) begin
                    n_state = S_FMT;
                end else if (i_start) begin
                    n_cmd   = i_req.command;
                    n_dw    = req_round[13] ? '1 : req_round[WORD_LOG +: SW];
                    n_fw    = PW'(i_req.data_offset[11:WORD_LOG] - 1'b1);
                    n_pos   = '0;
                    n_blk   = 1'b0;
                    n_acc   = '0;
                    n_res   = '0;
                    n_res.ok = (i_req.command == CMD_TOTAL) ||
                               (i_req.command == CMD_LARGEST);
                    if ((r_end == '0) ||
                        (i_req.command == CMD_ALLOC && i_req.request_bytes == '0) ||
                        (i_req.command == CMD_FREE &&
                         (i_req.data_offset < 12'(HDR_BYTES) ||
                          i_req.data_offset[WORD_LOG-1:0] != '0))) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_FMT: begin
                n_end = '0;
                if (pool_clamp >= 13'(HDR_BYTES) && el >= PW'(2)) begin
                    n_end   = el;
                    wr.en   = 1'b1;
                    wr.addr = '0;
                    wr.data = SW'(el - 1'b1);
                end
                n_state = S_IDLE;
            end
            S_LOAD: begin
                n_cur   = rd_data;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_FREE) begin
                    if (r_pos == r_fw) begin
                        if (!cur_free) begin
                            wr.en    = 1'b1;
                            wr.addr  = r_pos;
                            wr.data  = cur_mag;
                            n_res.ok = 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (nx_last || nx > r_fw) begin
                        n_state = S_DONE;
                    end else begin
                        n_pos   = nx;
                        rd_en   = 1'b1;
                        rd_addr = nx;
                        n_state = S_LOAD;
                    end
                end else if (merge_go) begin
                    rd_en   = 1'b1;
                    rd_addr = nx;
                    n_state = S_MERGE;
                end else if (r_cmd == CMD_ALLOC && fit) begin
                    wr.en   = 1'b1;
                    wr.addr = r_pos;
                    n_res.ok            = 1'b1;
                    n_res.result_offset = {PW'(r_pos + 1'b1), WORD_LOG'(0)};
                    if (rest >= PW'(2)) begin
                        wr.data    = SW'(0 - r_dw);
                        n_spl_addr = PW'(r_pos + r_dw + 1'b1);
                        n_spl_val  = SW'(rest - 1'b1);
                        n_state    = S_SPLIT;
                    end else begin
                        wr.data = SW'(0 - r_cur);
                        n_state = S_DONE;
                    end
                end else begin
                    n_acc = acc_n;
                    if (r_cmd != CMD_ALLOC) begin
                        n_res.amount = {1'b0, acc_n, WORD_LOG'(0)};
                    end
                    if (nx_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_pos   = nx;
                        n_blk   = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = nx;
                        n_state = S_LOAD;
                    end
                end
            end
            S_MERGE: begin
                if (!rd_data[SW-1]) begin
                    n_cur   = SW'(r_cur + rd_data + 1'b1);
                    wr.en   = 1'b1;
                    wr.addr = r_pos;
                    wr.data = n_cur;
                end else begin
                    n_blk = 1'b1;
                end
                n_state = S_EVAL;
            end
            S_SPLIT: begin
                wr.en   = 1'b1;
                wr.addr = r_spl_addr;
                wr.data = r_spl_val;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_dw       <= n_dw;
        r_fw       <= n_fw;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_blk      <= n_blk;
        r_acc      <= n_acc;
        r_spl_addr <= n_spl_addr;
        r_spl_val  <= n_spl_val;
        r_res      <= n_res;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

@@ rtl/core/first_fit_variable_block_allocator.sv @@
// A command refused up front (zero request, misaligned or low free offset, empty pool) goes
// straight to its result; else the walker loads and evaluates each block header in turn,
// reads and merges the next free header on each merge, and writes a second header on a split.
// Flow: one word at a time; the walker returns to idle in the cycle after its result is
// taken, and a stalled result holds the walker. Headers come from the header RAM (one read
// and one write port). Reset: synchronous, active low; pool_bytes returns to 4096 and the
// walker starts in its format state, so the pool is reformatted, as on every pool-size write.
module first_fit_variable_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [12:0] i_request_bytes,
    input  logic [11:0] i_data_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [11:0] o_result_offset,
    output logic [12:0] o_amount,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import ffa_pkg::*;

    logic        r_cfg_fmt;
    logic [12:0] r_pool_bytes;
    logic        r_out_valid;
    t_res        r_out;
    t_req        req;
    t_res        w_res;
    logic        w_idle, w_done, take, start, cfg_wr;

    assign req.command       = t_cmd'(i_command);
    assign req.request_bytes = i_request_bytes;
    assign req.data_offset   = i_data_offset;

    assign o_cfg_ready = w_idle && !r_cfg_fmt;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = w_idle && !r_cfg_fmt && !i_cfg_valid;
    assign start       = i_in_valid && o_in_ready;
    assign take        = w_done && (!r_out_valid || i_out_ready);

    ffa_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (req),
        .i_fmt        (r_cfg_fmt),
        .i_pool_bytes (r_pool_bytes),
        .i_take       (take),
        .o_idle       (w_idle),
        .o_done       (w_done),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes <= 13'(CAP_BYTES);
            r_cfg_fmt    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg_fmt <= cfg_wr;
            if (cfg_wr) begin
                r_pool_bytes <= i_cfg_data;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out.ok;
    assign o_result_offset = r_out.result_offset;
    assign o_amount        = r_out.amount;

endmodule

@@ rtl/core/ffa_chk.sv @@
module ffa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_ok,
    input logic [11:0] o_result_offset,
    input logic [12:0] o_amount
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("word or ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_offset)
            && $stable(o_amount) && $stable(o_ok))
        else $error("stalled word changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_result_offset == 12'd0 && o_amount == 13'd0)
        else $error("failed word carries data");

    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_offset != 12'd0 |->
            o_ok && o_amount == 13'd0 && o_result_offset[2:0] == 3'd0)
        else $error("bad allocation offset");

    a_amount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_amount != 13'd0 |->
            o_ok && o_result_offset == 12'd0 && o_amount[2:0] == 3'd0)
        else $error("bad free amount");

endmodule

bind first_fit_variable_block_allocator ffa_chk u_ffa_chk (.*);

@@ tb/ffa_checker.sv @@
`timescale 1ns / 1ps

module ffa_checker
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [12:0] i_request_bytes,
    input  logic [11:0] i_data_offset,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_ok,
    input  logic [11:0] i_result_offset,
    input  logic [12:0] i_amount,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_data,
    output int          o_fails,
    output int          o_pending
);

    localparam int unsigned HSPAN = (HDR_BYTES + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;

    int          hdr_sizes [POOL_WORDS];
    int unsigned pool_sz;
    int unsigned chain_end;
    t_res        expected_words [$];

    initial begin
        o_fails = 0;
        o_pending = 0;
    end

    function automatic int hdr_rd(int unsigned pos);
        if (pos / WORD_BYTES >= POOL_WORDS) return 0;
        return hdr_sizes[pos / WORD_BYTES];
    endfunction

    function automatic void hdr_wr(int unsigned pos, int v);
        if (pos / WORD_BYTES < POOL_WORDS) hdr_sizes[pos / WORD_BYTES] = v;
    endfunction

    function automatic int unsigned next_hdr(int unsigned pos);
        int          v;
        int unsigned nx;
        v = hdr_rd(pos);
        nx = pos + ((v < 0) ? -v : v) + HSPAN;
        return (nx > chain_end) ? chain_end : nx;
    endfunction

    function automatic void format_pool();
        int unsigned p;
        int unsigned el;
        p = (pool_sz > CAP_BYTES) ? CAP_BYTES : pool_sz;
        foreach (hdr_sizes[i]) hdr_sizes[i] = 0;
        chain_end = 0;
        if (p >= HSPAN) begin
            el = (p - HSPAN) - (p - HSPAN) % WORD_BYTES;
            if (el >= HSPAN + WORD_BYTES) begin
                hdr_wr(0, el - HSPAN);
                chain_end = el;
            end
        end
    endfunction

    // mode 0 first fit, 1 free total, 2 largest free; merges free neighbours on the way
    function automatic int unsigned walk_chain(int unsigned want, int mode,
                                               output int unsigned acc);
        int unsigned pos;
        int          cur;
        int unsigned nx;
        pos = 0;
        acc = 0;
        while (pos < chain_end) begin
            cur = hdr_rd(pos);
            nx = next_hdr(pos);
            if (cur >= 0 && nx < chain_end && hdr_rd(nx) >= 0) begin
                hdr_wr(pos, cur + hdr_rd(nx) + HSPAN);
                continue;
            end
            if (cur >= 0) begin
                if (mode == 0 && cur >= want) return pos;
                if (mode == 1) acc += cur;
                if (mode == 2 && cur > acc) acc = cur;
            end
            pos = nx;
        end
        return chain_end;
    endfunction

    function automatic t_res predict_word(t_cmd cmd, logic [12:0] req, logic [11:0] doff);
        t_res        r;
        int unsigned acc;
        int unsigned want;
        int unsigned pos;
        int unsigned rest;
        int unsigned f;
        int          cur;
        r = '0;
        case (cmd)
            CMD_ALLOC: begin
                if (req != 0) begin
                    want = (req + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
                    pos = walk_chain(want, 0, acc);
                    if (pos < chain_end) begin
                        cur = hdr_rd(pos);
                        rest = cur - want;
                        if (rest >= WORD_BYTES + HSPAN) begin
                            hdr_wr(pos, -int'(want));
                            hdr_wr(pos + want + HSPAN, rest - HSPAN);
                        end else begin
                            hdr_wr(pos, -cur);
                        end
                        r.ok = 1'b1;
                        r.result_offset = 12'(pos + HSPAN);
                    end
                end
            end
            CMD_FREE: begin
                if (doff >= HSPAN) begin
                    f = doff - HSPAN;
                    pos = 0;
                    while (pos < chain_end && pos <= f) begin
                        if (pos == f) begin
                            cur = hdr_rd(pos);
                            if (cur < 0) begin
                                hdr_wr(pos, -cur);
                                r.ok = 1'b1;
                            end
                            break;
                        end
                        pos = next_hdr(pos);
                    end
                end
            end
            default: begin
                void'(walk_chain(0, (cmd == CMD_TOTAL) ? 1 : 2, acc));
                r.ok = 1'b1;
                r.amount = 13'(acc);
            end
        endcase
        return r;
    endfunction

    task automatic report(string field, int got, int want);
        $display("tb: mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            pool_sz = 4096;
            format_pool();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                pool_sz = i_cfg_data;
                format_pool();
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", 1, 0);
                end else begin
                    w = expected_words.pop_front();
                    if (i_ok !== w.ok) report("ok", i_ok, w.ok);
                    if (i_result_offset !== w.result_offset)
                        report("result_offset", i_result_offset, w.result_offset);
                    if (i_amount !== w.amount) report("amount", i_amount, w.amount);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(predict_word(t_cmd'(i_command), i_request_bytes,
                                                      i_data_offset));
        end
        o_pending = expected_words.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ffa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [12:0] request_bytes;
    logic [11:0] data_offset;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [11:0] result_offset;
    logic [12:0] amount;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;
    int          fails;
    int          pending;
    bit          no_idle;
    logic [11:0] live_blocks [$];

    first_fit_variable_block_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_command(command), .i_request_bytes(request_bytes), .i_data_offset(data_offset),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_ok(ok), .o_result_offset(result_offset), .o_amount(amount),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    ffa_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_request_bytes(request_bytes), .i_data_offset(data_offset),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_ok(ok), .i_result_offset(result_offset), .i_amount(amount),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // live allocations, so frees mostly hit real blocks
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready && ok && result_offset != 0)
            live_blocks.push_back(result_offset);
    end

    initial begin
        int g;
        out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            g = no_idle ? 0 : $urandom_range(0, 10);
            if (g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_word(t_cmd c, logic [12:0] req, logic [11:0] off);
        int g;
        g = no_idle ? 0 : $urandom_range(0, 10);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        command <= c;
        request_bytes <= req;
        data_offset <= off;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_pool(logic [12:0] bytes);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= bytes;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        live_blocks.delete();
    endtask

    task automatic random_phase(int n, int unsigned pool);
        int          k;
        int          sel;
        logic [12:0] req;
        logic [11:0] off;
        for (int i = 0; i < n; i++) begin
            if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == n / 2) drain();
            sel = $urandom_range(0, 99);
            req = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                              : 13'($urandom_range(1, pool / 6 + 1));
            off = 12'($urandom_range(0, 4095));
            if (sel < 42) begin
                send_word(CMD_ALLOC, req, off);
            end else if (sel < 75) begin
                if (live_blocks.size() != 0 && $urandom_range(0, 4) != 0) begin
                    k = $urandom_range(0, live_blocks.size() - 1);
                    off = live_blocks[k];
                    if ($urandom_range(0, 5) != 0) live_blocks.delete(k);
                end
                send_word(CMD_FREE, req, off);
            end else if (sel < 87) begin
                send_word(CMD_TOTAL, req, off);
            end else begin
                send_word(CMD_LARGEST, req, off);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_bytes = '0;
        data_offset = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        no_idle = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(CMD_TOTAL, 13'h1fff, 12'hfff);
        send_word(CMD_LARGEST, '0, '0);
        send_word(CMD_ALLOC, 13'd0, '0);
        send_word(CMD_ALLOC, 13'd8191, '0);
        send_word(CMD_ALLOC, 13'd4096, '0);
        send_word(CMD_ALLOC, 13'd1, '0);
        send_word(CMD_ALLOC, 13'd9, '0);
        send_word(CMD_ALLOC, 13'd16, '0);
        send_word(CMD_FREE, '0, 12'd0);
        send_word(CMD_FREE, '0, 12'd4095);
        send_word(CMD_FREE, '0, 12'd20);
        send_word(CMD_FREE, '0, 12'd24);
        send_word(CMD_FREE, '0, 12'd24);
        send_word(CMD_FREE, '0, 12'd8);
        send_word(CMD_TOTAL, '0, '0);
        send_word(CMD_LARGEST, '0, '0);
        send_word(CMD_ALLOC, 13'd4064, '0);
        send_word(CMD_ALLOC, 13'd8, '0);
        send_word(CMD_LARGEST, '0, '0);
        write_pool(13'd24);
        send_word(CMD_ALLOC, 13'd8, '0);
        send_word(CMD_ALLOC, 13'd1, '0);
        send_word(CMD_TOTAL, '0, '0);
        write_pool(13'd8191);
        send_word(CMD_ALLOC, 13'd4080, '0);
        send_word(CMD_LARGEST, '0, '0);
        send_word(CMD_FREE, '0, 12'd8);

        write_pool(13'd4096);
        random_phase(120, 4096);
        write_pool(13'd200);
        random_phase(60, 200);
        write_pool(13'd24);
        random_phase(20, 24);
        write_pool(13'd1000);
        random_phase(80, 1000);
        write_pool(13'd8191);
        random_phase(80, 4096);
        write_pool(13'd4096);
        random_phase(90, 4096);

        drain();
        repeat (50) @(negedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
